// ===== sv/integer_to_decimal_ascii_defines.svh =====
// assertion macros for the integer to decimal ascii converter
// used by the top level, which provides clk and rst_n in scope
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define I2DA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2da assertion failed");
`define I2DA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2da assertion failed");
`else
`define I2DA_ASSERT(lbl, prop)
`define I2DA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/i2da_pkg.sv =====
// shared widths, ascii codes and cell operation codes
// no dependencies
package i2da_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int LEN_W      = 5;
  localparam int CONV_STEPS = VALUE_W;
  localparam int STEP_W     = $clog2(CONV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_DABBLE,
    OP_DIGIT
  } cell_op_t;

endpackage

// ===== sv/i2da_cell.sv =====
// one decimal digit cell of the conversion chain
// depends on i2da_pkg
module i2da_cell (
  input  logic                          clk,
  input  i2da_pkg::cell_op_t            op,
  input  logic                          bit_in,
  input  logic [i2da_pkg::DIGIT_W-1:0]  digit_in,
  output logic                          bit_out,
  output logic [i2da_pkg::DIGIT_W-1:0]  digit_out
);

  logic [i2da_pkg::DIGIT_W-1:0] digit_r;
  logic [i2da_pkg::DIGIT_W-1:0] adj;

  // add 3 before the shift when the digit would pass nine
  always_comb begin
    adj = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  end

  assign bit_out   = adj[i2da_pkg::DIGIT_W-1];
  assign digit_out = digit_r;

  always_ff @(posedge clk) begin
    case (op)
      i2da_pkg::OP_CLEAR:  digit_r <= '0;
      i2da_pkg::OP_DABBLE: digit_r <= {adj[i2da_pkg::DIGIT_W-2:0], bit_in};
      i2da_pkg::OP_DIGIT:  digit_r <= digit_in;
      default:             digit_r <= digit_r;
    endcase
  end

endmodule

// ===== sv/integer_to_decimal_ascii.sv =====
// top level: 64-bit integer to decimal ascii text, one character per output transfer
// depends on i2da_pkg, i2da_cell and integer_to_decimal_ascii_defines.svh
//
//   channel   direction  ports
//   in        input      in_valid, in_stall, in_value_bits, in_is_signed
//   out       output     out_valid, out_stall, out_character, out_text_length,
//                        out_last_char
//
// one input item is loaded, then takes 64 shift-add-3 steps through the row of
// 20 digit cells, then drops up to 19 leading zero digits (one per cycle),
// then gives one character per cycle while out_stall is low.
// reset clears the control state only; the digit cells are cleared on load.
// out_stall holds the current character; in_stall is high until the last
// character of the item is taken.
`include "integer_to_decimal_ascii_defines.svh"

module integer_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [i2da_pkg::VALUE_W-1:0]    in_value_bits,
  input  logic                            in_is_signed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [i2da_pkg::CHAR_W-1:0]     out_character,
  output logic [i2da_pkg::LEN_W-1:0]      out_text_length,
  output logic                            out_last_char
);

  localparam int N = i2da_pkg::NUM_DIGITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                          state_r;
  logic [i2da_pkg::VALUE_W-1:0]    mag_r;
  logic                            neg_r;
  logic [i2da_pkg::STEP_W-1:0]     cnt_r;
  logic [i2da_pkg::LEN_W-1:0]      ndig_r;
  logic [i2da_pkg::LEN_W-1:0]      total_r;

  i2da_pkg::cell_op_t              cell_op;
  logic [N-1:0]                    bit_link;
  logic                            top_carry;
  logic [i2da_pkg::DIGIT_W-1:0]    digit_link [N+1];
  logic [i2da_pkg::DIGIT_W-1:0]    top_digit;
  logic                            in_neg;
  logic                            out_take;
  logic                            trim_step;

  assign in_neg    = in_is_signed & in_value_bits[i2da_pkg::VALUE_W-1];
  assign top_digit = digit_link[N];
  assign out_take  = out_valid & ~out_stall;
  assign trim_step = (top_digit == '0) && (ndig_r > 5'd1);

  assign bit_link[0]   = mag_r[i2da_pkg::VALUE_W-1];
  assign digit_link[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i < N - 1) begin : g_mid
      i2da_cell u_cell (
        .clk       (clk),
        .op        (cell_op),
        .bit_in    (bit_link[i]),
        .digit_in  (digit_link[i]),
        .bit_out   (bit_link[i+1]),
        .digit_out (digit_link[i+1])
      );
    end else begin : g_top
      i2da_cell u_cell (
        .clk       (clk),
        .op        (cell_op),
        .bit_in    (bit_link[i]),
        .digit_in  (digit_link[i]),
        .bit_out   (top_carry),
        .digit_out (digit_link[i+1])
      );
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  cell_op = in_valid ? i2da_pkg::OP_CLEAR : i2da_pkg::OP_HOLD;
      S_CONV:  cell_op = i2da_pkg::OP_DABBLE;
      S_TRIM:  cell_op = trim_step ? i2da_pkg::OP_DIGIT : i2da_pkg::OP_HOLD;
      S_EMIT:  cell_op = out_take ? i2da_pkg::OP_DIGIT : i2da_pkg::OP_HOLD;
      default: cell_op = i2da_pkg::OP_HOLD;
    endcase
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_SIGN) || (state_r == S_EMIT);
  assign out_character   = (state_r == S_SIGN) ? i2da_pkg::CHAR_MINUS
                         : i2da_pkg::CHAR_ZERO + {2'b00, top_digit};
  assign out_text_length = total_r;
  assign out_last_char   = (state_r == S_EMIT) && (ndig_r == 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ndig_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mag_r   <= in_neg ? (~in_value_bits + 64'd1) : in_value_bits;
            neg_r   <= in_neg;
            cnt_r   <= '0;
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          mag_r <= {mag_r[i2da_pkg::VALUE_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == i2da_pkg::STEP_W'(i2da_pkg::CONV_STEPS - 1)) begin
            ndig_r  <= i2da_pkg::LEN_W'(N);
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          // drop one leading zero digit per cycle, keep at least one digit
          if (trim_step) begin
            ndig_r <= ndig_r - 1'b1;
          end else begin
            total_r <= ndig_r + {{(i2da_pkg::LEN_W-1){1'b0}}, neg_r};
            state_r <= neg_r ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (!out_stall) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            ndig_r <= ndig_r - 1'b1;
            if (ndig_r == 5'd1) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no digit overflow out of the top cell during conversion
  `I2DA_ASSERT(a_no_top_carry, (state_r == S_CONV) |-> !top_carry)
  `I2DA_ASSERT(a_busy_when_out, out_valid |-> in_stall)
  `I2DA_ASSERT(a_digit_range, (state_r == S_EMIT) |-> (top_digit <= 4'd9))
  `I2DA_ASSERT(a_last_not_sign, out_last_char |-> (out_character != i2da_pkg::CHAR_MINUS))
  `I2DA_ASSERT(a_free_after_last, (out_take && out_last_char) |=> !in_stall)
  `I2DA_ASSERT(a_len_range, out_valid |-> ((total_r != 5'd0) && (total_r <= 5'd20)))

endmodule
